// File: sv/prmt_pkg.sv
// ----------------------------------------------------------------------------
// prmt_pkg
// Shared constants and types of the point range min/max tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package prmt_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int RANGE_W        = 16;
  localparam logic [RANGE_W-1:0] RANGE_MAX = '1;
  localparam logic [RANGE_W-1:0] RANGE_MIN = '0;
  localparam int QUEUE_DEPTH    = 4;

  // Occupancy status that the queue reports to its producer and consumer.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

// File: sv/prmt_if.sv
// ----------------------------------------------------------------------------
// prmt_if
// Valid/ready channels for incoming points and outgoing range results.
// ----------------------------------------------------------------------------
`default_nettype none

interface prmt_in_if import prmt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic                         last_of_frame;

  modport source (output valid, coord_x, coord_y, coord_z, last_of_frame, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, last_of_frame, output ready);
endinterface

interface prmt_out_if import prmt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] range_mm;
  logic [RANGE_W-1:0] running_min;
  logic [RANGE_W-1:0] running_max;
  logic               frame_done;

  modport source (output valid, range_mm, running_min, running_max, frame_done, input ready);
  modport sink   (input valid, range_mm, running_min, running_max, frame_done, output ready);
endinterface

`default_nettype wire

// File: sv/prmt_front.sv
// ----------------------------------------------------------------------------
// prmt_front
// Accepts points, registers coordinate magnitudes and pushes the exact
// squared distance into the work queue.
// ----------------------------------------------------------------------------
`default_nettype none

module prmt_front import prmt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  prmt_in_if.sink                 points,
  input  wire q_stat_t            q_stat,
  output logic                    push,
  output logic [2*COORD_BITS+2:0] push_data
);

  localparam int SQ_W = 2 * COORD_BITS + 2;

  logic                  s1_valid;
  logic [COORD_BITS-1:0] s1_mx;
  logic [COORD_BITS-1:0] s1_my;
  logic [COORD_BITS-1:0] s1_mz;
  logic                  s1_last;

  logic [2*COORD_BITS-1:0] px;
  logic [2*COORD_BITS-1:0] py;
  logic [2*COORD_BITS-1:0] pz;
  logic [SQ_W-1:0]         sq;
  logic                    accept;

  function automatic logic [COORD_BITS-1:0] mag(input logic [COORD_BITS-1:0] v);
    // The most negative value maps onto itself, which is its correct magnitude.
    return v[COORD_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  assign push          = s1_valid && !q_stat.full;
  assign points.ready  = !s1_valid || !q_stat.full;
  assign accept        = points.valid && points.ready;

  assign px = s1_mx * s1_mx;
  assign py = s1_my * s1_my;
  assign pz = s1_mz * s1_mz;
  assign sq = SQ_W'(px) + SQ_W'(py) + SQ_W'(pz);
  assign push_data = {s1_last, sq};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mx   <= mag(points.coord_x);
      s1_my   <= mag(points.coord_y);
      s1_mz   <= mag(points.coord_z);
      s1_last <= points.last_of_frame;
    end
  end

endmodule

`default_nettype wire

// File: sv/prmt_queue.sv
// ----------------------------------------------------------------------------
// prmt_queue
// Small register queue between the front and the square-root back end.
// ----------------------------------------------------------------------------
`default_nettype none

module prmt_queue import prmt_pkg::*; #(
  parameter int DATA_W = 2 * COORD_BITS_DEF + 3,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      head,
  output q_stat_t                q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == CNT_W'(DEPTH));
  assign head         = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: sv/prmt_back.sv
// ----------------------------------------------------------------------------
// prmt_back
// Bit-serial integer square root, frame min/max trackers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module prmt_back import prmt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire q_stat_t            q_stat,
  input  wire logic [2*COORD_BITS+2:0] head,
  output logic                    pop,
  prmt_out_if.source              ranges
);

  localparam int SQ_W  = 2 * COORD_BITS + 2;
  localparam int RW    = COORD_BITS + 1;
  localparam int REM_W = RW + 3;
  localparam int CNT_W = $clog2(RW + 1);
  localparam int EXT_W = (RW > RANGE_W) ? RW : RANGE_W;

  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_CALC = 2'd1;
  localparam logic [1:0] BK_DONE = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] cnt;
  logic [SQ_W-1:0]  n;
  logic [REM_W-1:0] rem;
  logic [RW-1:0]    root;
  logic             last;

  logic [RANGE_W-1:0] min_tracker;
  logic [RANGE_W-1:0] max_tracker;

  logic               out_valid;
  logic [RANGE_W-1:0] res_range;
  logic [RANGE_W-1:0] res_min;
  logic [RANGE_W-1:0] res_max;
  logic               res_done;

  logic [REM_W-1:0]   rem_sh;
  logic [REM_W-1:0]   trial;
  logic               fits;
  logic [EXT_W-1:0]   root_ext;
  logic [RANGE_W-1:0] range_sat;
  logic [RANGE_W-1:0] min_next;
  logic [RANGE_W-1:0] max_next;
  logic               out_load;

  // One root bit per cycle: bring down the next pair of radicand bits.
  assign rem_sh = {rem[REM_W-3:0], n[SQ_W-1 -: 2]};
  assign trial  = REM_W'({root, 2'b01});
  assign fits   = (rem_sh >= trial);

  assign root_ext  = EXT_W'(root);
  assign range_sat = (root_ext > EXT_W'(RANGE_MAX)) ? RANGE_MAX : root_ext[RANGE_W-1:0];
  assign min_next  = (range_sat < min_tracker) ? range_sat : min_tracker;
  assign max_next  = (range_sat > max_tracker) ? range_sat : max_tracker;

  assign pop      = (state == BK_IDLE) && !q_stat.empty;
  assign out_load = (state == BK_DONE) && (!out_valid || ranges.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      cnt         <= '0;
      min_tracker <= RANGE_MAX;
      max_tracker <= RANGE_MIN;
      out_valid   <= 1'b0;
    end else begin
      case (state)
        BK_IDLE: begin
          if (pop) begin
            state <= BK_CALC;
            cnt   <= CNT_W'(RW);
          end
        end
        BK_CALC: begin
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            state <= BK_DONE;
          end
        end
        BK_DONE: begin
          if (out_load) begin
            state <= BK_IDLE;
          end
        end
        default: begin
          state <= BK_IDLE;
        end
      endcase

      if (out_load) begin
        out_valid   <= 1'b1;
        min_tracker <= last ? RANGE_MAX : min_next;
        max_tracker <= last ? RANGE_MIN : max_next;
      end else if (ranges.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      n    <= head[SQ_W-1:0];
      last <= head[SQ_W];
      rem  <= '0;
      root <= '0;
    end else if (state == BK_CALC) begin
      n    <= {n[SQ_W-3:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[RW-2:0], fits};
    end
    if (out_load) begin
      res_range <= range_sat;
      res_min   <= min_next;
      res_max   <= max_next;
      res_done  <= last;
    end
  end

  assign ranges.valid       = out_valid;
  assign ranges.range_mm    = res_range;
  assign ranges.running_min = res_min;
  assign ranges.running_max = res_max;
  assign ranges.frame_done  = res_done;

  // Every delivered range lies inside the frame extremes that go with it.
  a_minmax_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res_min <= res_range && res_range <= res_max))
    else $error("range outside running min/max");

  // The queue is only drained by an idle root unit.
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == BK_IDLE && !q_stat.empty))
    else $error("pop while busy or queue empty");

  a_calc_count: assert property (@(posedge clk) disable iff (rst)
    (state == BK_CALC) |-> (cnt != '0))
    else $error("iteration count ran out during root");

  // A frame end returns both trackers to their reset values.
  a_frame_reset: assert property (@(posedge clk) disable iff (rst)
    (out_load && last) |=> (min_tracker == RANGE_MAX && max_tracker == RANGE_MIN))
    else $error("trackers not cleared after frame end");

endmodule

`default_nettype wire

// File: sv/point_range_minmax_tracker.sv
// ----------------------------------------------------------------------------
// point_range_minmax_tracker
// Radial range of 3D points with per-frame running minimum and maximum.
// ----------------------------------------------------------------------------
// Each accepted point yields one result beat: the floor square root of
// x*x+y*y+z*z, saturated to 16 bits, plus the smallest and largest range of
// the frame so far, counting this point. A point marked last_of_frame closes
// the frame: its result carries the final extremes and the trackers then
// restart. The front takes a point per cycle while the queue has room and
// forms the exact squared distance; up to four such values wait in a queue.
// The back end extracts the root one bit per cycle, taking a new value only
// after the last result is registered; that shared root unit sets the
// sustained rate. Short bursts are absorbed by the front register and queue.
`default_nettype none

module point_range_minmax_tracker import prmt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  prmt_in_if.sink    points,
  prmt_out_if.source ranges
);

  localparam int Q_W = 2 * COORD_BITS + 3;

  q_stat_t        q_stat;
  logic           push;
  logic [Q_W-1:0] push_data;
  logic           pop;
  logic [Q_W-1:0] head;

  prmt_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .points    (points),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  prmt_queue #(.DATA_W(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  prmt_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_stat (q_stat),
    .head   (head),
    .pop    (pop),
    .ranges (ranges)
  );

endmodule

`default_nettype wire
